// ===== design/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check under reset guard
`define KPCT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kpct assertion failed");

// check with no reset guard
`define KPCT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("kpct assertion failed");

`endif

// ===== design/kpct_pkg.sv =====
// constants and helpers for the keypad-set countdown timer
package kpct_pkg;

  localparam logic       OpKey     = 1'b0;
  localparam logic       OpTick    = 1'b1;

  localparam logic [4:0] KeyNone   = 5'd0;
  localparam logic [4:0] KeyRight  = 5'd10;
  localparam logic [4:0] KeyZero   = 5'd11;
  localparam logic [4:0] KeyLeft   = 5'd12;
  localparam logic [4:0] KeyStart  = 5'd13;
  localparam logic [4:0] KeyDigMax = 5'd9;

  localparam logic [2:0] SecTensMax = 3'd5;
  localparam logic [5:0] SecondsTop = 6'd59;

  localparam logic [1:0] CurMinTens = 2'd0;
  localparam logic [1:0] CurMinUnit = 2'd1;
  localparam logic [1:0] CurSecTens = 2'd2;
  localparam logic [1:0] CurSecUnit = 2'd3;

  function automatic logic [6:0] times_ten(input logic [3:0] d);
    times_ten = 7'({d, 3'b000}) + 7'({d, 1'b0});
  endfunction

endpackage

// ===== design/keypad_set_countdown_timer_unit.sv =====
// top level of the keypad-set countdown timer
//
// input channel: in_valid / in_stall with in_operation (0 key sample, 1 second
// tick) and in_key_code. result channel: out_valid / out_stall carrying the
// entered time, cursor, remaining time, running and the finished pulse.
// one result item for every input item, in order.
// an accepted item waits in the input register; the timer state and the
// result register are updated together when it moves on, which a stall
// of the receiver can hold off.
// throughput is one item per clock while the receiver does not stall: the
// update between input and result register is a single pass.
// when the receiver stalls, the result register holds its item, the input
// register holds the next one and in_stall rises once both are full.
// synchronous active-low reset clears the digits, cursor, countdown, key
// tracking and both valid flags.
module keypad_set_countdown_timer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [4:0] in_key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_set_minutes,
  output logic [5:0] out_set_seconds,
  output logic [1:0] out_cursor_position,
  output logic [6:0] out_remaining_minutes,
  output logic [5:0] out_remaining_seconds,
  output logic       out_running,
  output logic       out_finished
);

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_op_r;
  logic [4:0] s1_key_r;

  logic       key_held_r, key_held_nxt;
  logic [1:0] cursor_r, cursor_nxt;
  logic [3:0] min_tens_r, min_tens_nxt;
  logic [3:0] min_unit_r, min_unit_nxt;
  logic [2:0] sec_tens_r, sec_tens_nxt;
  logic [3:0] sec_unit_r, sec_unit_nxt;
  logic [6:0] min_left_r, min_left_nxt;
  logic [5:0] sec_left_r, sec_left_nxt;
  logic       counting_r, counting_nxt;
  logic       fin_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [6:0] out_set_min_r;
  logic [5:0] out_set_sec_r;
  logic [1:0] out_cursor_r;
  logic [6:0] out_rem_min_r;
  logic [5:0] out_rem_sec_r;
  logic       out_running_r;
  logic       out_fin_r;

  logic       adv;
  logic       move;
  logic       accept;
  logic       press;
  logic       is_digit;
  logic [3:0] dig;

  assign adv    = !out_valid_r || !out_stall;
  assign move   = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign accept = in_valid && !in_stall;

  assign press    = (s1_op_r == kpct_pkg::OpKey) && !key_held_r
                    && (s1_key_r != kpct_pkg::KeyNone);
  assign is_digit = (s1_key_r != kpct_pkg::KeyNone) && (s1_key_r <= kpct_pkg::KeyDigMax);
  assign dig      = (s1_key_r == kpct_pkg::KeyZero) ? 4'd0 : s1_key_r[3:0];

  always_comb begin
    key_held_nxt = key_held_r;
    cursor_nxt   = cursor_r;
    min_tens_nxt = min_tens_r;
    min_unit_nxt = min_unit_r;
    sec_tens_nxt = sec_tens_r;
    sec_unit_nxt = sec_unit_r;
    min_left_nxt = min_left_r;
    sec_left_nxt = sec_left_r;
    counting_nxt = counting_r;
    fin_nxt      = 1'b0;
    if (s1_op_r == kpct_pkg::OpKey) begin
      key_held_nxt = (s1_key_r != kpct_pkg::KeyNone);
      if (press) begin
        if (!counting_r) begin
          if (s1_key_r == kpct_pkg::KeyRight) begin
            cursor_nxt = cursor_r + 2'd1;
          end else if (s1_key_r == kpct_pkg::KeyLeft) begin
            cursor_nxt = cursor_r - 2'd1;
          end else if (is_digit || s1_key_r == kpct_pkg::KeyZero) begin
            case (cursor_r)
              kpct_pkg::CurMinTens: min_tens_nxt = dig;
              kpct_pkg::CurMinUnit: min_unit_nxt = dig;
              kpct_pkg::CurSecTens: begin
                if (dig <= 4'(kpct_pkg::SecTensMax)) sec_tens_nxt = dig[2:0];
              end
              default: sec_unit_nxt = dig;
            endcase
          end
        end
        if (s1_key_r == kpct_pkg::KeyStart) begin
          min_left_nxt = kpct_pkg::times_ten(min_tens_r) + 7'(min_unit_r);
          sec_left_nxt = 6'(kpct_pkg::times_ten({1'b0, sec_tens_r})) + 6'(sec_unit_r);
          counting_nxt = 1'b1;
        end
      end
    end else if (counting_r) begin
      if (sec_left_r != 6'd0) begin
        sec_left_nxt = sec_left_r - 6'd1;
      end else if (min_left_r != 7'd0) begin
        min_left_nxt = min_left_r - 7'd1;
        sec_left_nxt = kpct_pkg::SecondsTop;
      end
      if (sec_left_nxt == 6'd0 && min_left_nxt == 7'd0) begin
        fin_nxt      = 1'b1;
        counting_nxt = 1'b0;
        min_tens_nxt = 4'd0;
        min_unit_nxt = 4'd0;
        sec_tens_nxt = 3'd0;
        sec_unit_nxt = 4'd0;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      key_held_r  <= 1'b0;
      cursor_r    <= kpct_pkg::CurMinTens;
      min_tens_r  <= 4'd0;
      min_unit_r  <= 4'd0;
      sec_tens_r  <= 3'd0;
      sec_unit_r  <= 4'd0;
      min_left_r  <= 7'd0;
      sec_left_r  <= 6'd0;
      counting_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (move) begin
        key_held_r <= key_held_nxt;
        cursor_r   <= cursor_nxt;
        min_tens_r <= min_tens_nxt;
        min_unit_r <= min_unit_nxt;
        sec_tens_r <= sec_tens_nxt;
        sec_unit_r <= sec_unit_nxt;
        min_left_r <= min_left_nxt;
        sec_left_r <= sec_left_nxt;
        counting_r <= counting_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= in_operation;
      s1_key_r <= in_key_code;
    end
    if (move) begin
      out_set_min_r <= kpct_pkg::times_ten(min_tens_nxt) + 7'(min_unit_nxt);
      out_set_sec_r <= 6'(kpct_pkg::times_ten({1'b0, sec_tens_nxt})) + 6'(sec_unit_nxt);
      out_cursor_r  <= cursor_nxt;
      out_rem_min_r <= min_left_nxt;
      out_rem_sec_r <= sec_left_nxt;
      out_running_r <= counting_nxt;
      out_fin_r     <= fin_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_set_minutes       = out_set_min_r;
  assign out_set_seconds       = out_set_sec_r;
  assign out_cursor_position   = out_cursor_r;
  assign out_remaining_minutes = out_rem_min_r;
  assign out_remaining_seconds = out_rem_sec_r;
  assign out_running           = out_running_r;
  assign out_finished          = out_fin_r;

endmodule

// ===== design/kpct_checker.sv =====
// port-level checker for the countdown timer, bound to the top level
`include "assert_macros.svh"

module kpct_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_set_minutes,
  input logic [5:0] out_set_seconds,
  input logic [6:0] out_remaining_minutes,
  input logic [5:0] out_remaining_seconds,
  input logic       out_running,
  input logic       out_finished
);

  `KPCT_ASSERT_ALWAYS(a_reset_clears_valid, clk, !rst_n |=> !out_valid)

  `KPCT_ASSERT(a_fin_stops, clk, rst_n, (out_valid && out_finished) |-> (!out_running
    && out_remaining_minutes == 7'd0 && out_remaining_seconds == 6'd0))

  `KPCT_ASSERT(a_fin_clears, clk, rst_n, (out_valid && out_finished) |->
    (out_set_minutes == 7'd0 && out_set_seconds == 6'd0))

  `KPCT_ASSERT(a_seconds_range, clk, rst_n, out_valid |->
    (out_remaining_seconds <= kpct_pkg::SecondsTop && out_set_seconds <= kpct_pkg::SecondsTop))

  `KPCT_ASSERT(a_stall_holds, clk, rst_n, (out_valid && out_stall) |=>
    (out_valid && $stable(out_remaining_seconds) && $stable(out_finished)))

endmodule

bind keypad_set_countdown_timer_unit kpct_checker u_kpct_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_set_minutes       (out_set_minutes),
  .out_set_seconds       (out_set_seconds),
  .out_remaining_minutes (out_remaining_minutes),
  .out_remaining_seconds (out_remaining_seconds),
  .out_running           (out_running),
  .out_finished          (out_finished)
);

// ===== sim/tb_top.sv =====
// testbench for the keypad-set countdown timer: directed table, then keypad sessions vs predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] set_min;
    logic [5:0] set_sec;
    logic [1:0] cur;
    logic [6:0] rem_min;
    logic [5:0] rem_sec;
    logic       run;
    logic       fin;
  } readout_t;

  typedef struct packed {
    logic       held;
    logic [1:0] cur;
    logic [3:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
    logic [6:0] min_left;
    logic [5:0] sec_left;
    logic       run;
  } timer_t;

  typedef struct packed {
    logic       op;
    logic [4:0] key;
    logic       typed;
    readout_t   want;
  } step_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_operation = kpct_pkg::OpKey;
  logic [4:0] in_key_code = kpct_pkg::KeyNone;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_set_minutes;
  logic [5:0] out_set_seconds;
  logic [1:0] out_cursor_position;
  logic [6:0] out_remaining_minutes;
  logic [5:0] out_remaining_seconds;
  logic       out_running;
  logic       out_finished;

  timer_t   timer_now = '0;
  readout_t pending_readouts[$];
  step_t    steps[$];
  int       errors = 0;
  int       readouts_seen = 0;
  int       items_sent = 0;
  int       send_idle = 0;
  int       recv_idle = 0;

  keypad_set_countdown_timer_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_key_code          (in_key_code),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_set_minutes      (out_set_minutes),
    .out_set_seconds      (out_set_seconds),
    .out_cursor_position  (out_cursor_position),
    .out_remaining_minutes(out_remaining_minutes),
    .out_remaining_seconds(out_remaining_seconds),
    .out_running          (out_running),
    .out_finished         (out_finished)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void put_digit(input logic [3:0] d);
    case (timer_now.cur)
      kpct_pkg::CurMinTens: timer_now.min_tens = d;
      kpct_pkg::CurMinUnit: timer_now.min_units = d;
      kpct_pkg::CurSecTens: if (d <= 4'(kpct_pkg::SecTensMax)) timer_now.sec_tens = d[2:0];
      default:              timer_now.sec_units = d;
    endcase
  endfunction

  function automatic readout_t advance_timer(input logic op, input logic [4:0] key);
    readout_t r;
    r = '0;
    if (op == kpct_pkg::OpKey) begin
      if (!timer_now.held && key != kpct_pkg::KeyNone) begin
        if (!timer_now.run) begin
          if (key == kpct_pkg::KeyRight) timer_now.cur = timer_now.cur + 2'd1;
          else if (key == kpct_pkg::KeyLeft) timer_now.cur = timer_now.cur - 2'd1;
          else if (key <= kpct_pkg::KeyDigMax) put_digit(key[3:0]);
          else if (key == kpct_pkg::KeyZero) put_digit(4'd0);
        end
        if (key == kpct_pkg::KeyStart) begin
          timer_now.min_left = 7'(timer_now.min_tens) * 7'd10 + 7'(timer_now.min_units);
          timer_now.sec_left = 6'(timer_now.sec_tens) * 6'd10 + 6'(timer_now.sec_units);
          timer_now.run = 1'b1;
        end
      end
      timer_now.held = (key != kpct_pkg::KeyNone);
    end else if (timer_now.run) begin
      if (timer_now.sec_left != 6'd0) begin
        timer_now.sec_left = timer_now.sec_left - 6'd1;
      end else if (timer_now.min_left != 7'd0) begin
        timer_now.min_left = timer_now.min_left - 7'd1;
        timer_now.sec_left = kpct_pkg::SecondsTop;
      end
      if (timer_now.sec_left == 6'd0 && timer_now.min_left == 7'd0) begin
        r.fin = 1'b1;
        timer_now.run = 1'b0;
        timer_now.min_tens = 4'd0;
        timer_now.min_units = 4'd0;
        timer_now.sec_tens = 3'd0;
        timer_now.sec_units = 4'd0;
      end
    end
    r.set_min = 7'(timer_now.min_tens) * 7'd10 + 7'(timer_now.min_units);
    r.set_sec = 6'(timer_now.sec_tens) * 6'd10 + 6'(timer_now.sec_units);
    r.cur = timer_now.cur;
    r.rem_min = timer_now.min_left;
    r.rem_sec = timer_now.sec_left;
    r.run = timer_now.run;
    return r;
  endfunction

  function automatic readout_t shows(input int sm, input int ss, input int cur, input int rm,
                                     input int rs, input int run, input int fin);
    return '{set_min: 7'(sm), set_sec: 6'(ss), cur: 2'(cur), rem_min: 7'(rm),
             rem_sec: 6'(rs), run: 1'(run), fin: 1'(fin)};
  endfunction

  function automatic step_t plain(input logic op, input logic [4:0] key);
    return '{op: op, key: key, typed: 1'b0, want: '0};
  endfunction

  function automatic step_t known(input logic op, input logic [4:0] key, input readout_t want);
    return '{op: op, key: key, typed: 1'b1, want: want};
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    if (errors <= 100) $display("item %0d: %s got %0d want %0d", readouts_seen, what, got, want);
  endtask

  task automatic check_readout(input readout_t want);
    if (out_set_minutes !== want.set_min) report("set_minutes", out_set_minutes, want.set_min);
    if (out_set_seconds !== want.set_sec) report("set_seconds", out_set_seconds, want.set_sec);
    if (out_cursor_position !== want.cur) report("cursor", out_cursor_position, want.cur);
    if (out_remaining_minutes !== want.rem_min)
      report("remaining_minutes", out_remaining_minutes, want.rem_min);
    if (out_remaining_seconds !== want.rem_sec)
      report("remaining_seconds", out_remaining_seconds, want.rem_sec);
    if (out_running !== want.run) report("running", out_running, want.run);
    if (out_finished !== want.fin) report("finished", out_finished, want.fin);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readouts.size() == 0) report("result with none expected", 1, 0);
      else check_readout(pending_readouts.pop_front());
      readouts_seen++;
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic send_item(input logic op, input logic [4:0] key, input logic typed = 1'b0,
                           input readout_t want = '0);
    readout_t predicted;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_key_code <= key;
    do @(posedge clk); while (in_stall);
    predicted = advance_timer(op, key);
    pending_readouts.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // held for a few samples, sometimes a second key while held, usually released
  task automatic press(input logic [4:0] key);
    repeat ($urandom_range(1, 3)) send_item(kpct_pkg::OpKey, key);
    if ($urandom_range(9) == 0) send_item(kpct_pkg::OpKey, 5'($urandom_range(1, 31)));
    if ($urandom_range(19) != 0) repeat ($urandom_range(1, 2))
      send_item(kpct_pkg::OpKey, kpct_pkg::KeyNone);
  endtask

  task automatic steer(input logic [15:0] want_digs);
    logic [4:0]  dir;
    logic [15:0] now_digs;
    logic [3:0]  want;
    for (int p = 0; p < 4; p++) begin
      dir = $urandom_range(1) ? kpct_pkg::KeyRight : kpct_pkg::KeyLeft;
      want = want_digs[4 * (3 - p) +: 4];
      forever begin
        now_digs = {timer_now.min_tens, timer_now.min_units, {1'b0, timer_now.sec_tens},
                    timer_now.sec_units};
        if (timer_now.run) break;
        if (timer_now.cur == 2'(p) && now_digs[4 * (3 - p) +: 4] == want) break;
        if (timer_now.cur != 2'(p)) press(dir);
        else press(want == 4'd0 ? kpct_pkg::KeyZero : 5'(want));
      end
    end
  endtask

  task automatic run_session(input logic [15:0] want_digs, input int tick_cap);
    int ticks;
    ticks = 0;
    repeat ($urandom_range(4)) press(5'($urandom_range(1, 12)));
    steer(want_digs);
    press(kpct_pkg::KeyStart);
    while (timer_now.run && ticks < tick_cap) begin
      if ($urandom_range(99) < 4) press(5'($urandom_range(1, 31)));
      else send_item(kpct_pkg::OpTick, 5'($urandom_range(31)));
      ticks++;
    end
  endtask

  // setup-mode noise, start kept out so no long countdown is loaded
  task automatic send_noise();
    logic       op;
    logic [4:0] key;
    repeat ($urandom_range(5, 15)) begin
      op = 1'($urandom_range(1));
      key = 5'($urandom_range(31));
      if (op == kpct_pkg::OpKey && key == kpct_pkg::KeyStart && !timer_now.run)
        key = kpct_pkg::KeyNone;
      send_item(op, key);
    end
  endtask

  initial begin
    int goal;
    steps = '{
      known(kpct_pkg::OpTick, kpct_pkg::KeyNone, shows(0, 0, 0, 0, 0, 0, 0)),
      known(kpct_pkg::OpKey, kpct_pkg::KeyStart, shows(0, 0, 0, 0, 0, 1, 0)),
      known(kpct_pkg::OpTick, 5'd31, shows(0, 0, 0, 0, 0, 0, 1)),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      known(kpct_pkg::OpKey, kpct_pkg::KeyLeft, shows(0, 0, 3, 0, 0, 0, 0)),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      known(kpct_pkg::OpKey, kpct_pkg::KeyRight, shows(0, 0, 0, 0, 0, 0, 0)),
      known(kpct_pkg::OpKey, 5'd7, shows(0, 0, 0, 0, 0, 0, 0)),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      plain(kpct_pkg::OpKey, 5'd20),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      known(kpct_pkg::OpKey, 5'd9, shows(90, 0, 0, 0, 0, 0, 0)),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      known(kpct_pkg::OpKey, kpct_pkg::KeyZero, shows(0, 0, 0, 0, 0, 0, 0)),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyLeft),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyLeft),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      plain(kpct_pkg::OpKey, 5'd9),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      plain(kpct_pkg::OpKey, 5'd5),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyStart),
      plain(kpct_pkg::OpTick, 5'd31),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      plain(kpct_pkg::OpKey, 5'd3),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyNone),
      plain(kpct_pkg::OpKey, kpct_pkg::KeyStart)
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 21;
    recv_idle = 75;
    foreach (steps[i]) send_item(steps[i].op, steps[i].key, steps[i].typed, steps[i].want);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 21 : (ph == 1) ? 75 : 0;
      recv_idle = (ph == 0) ? 75 : (ph == 1) ? 21 : 0;
      goal = items_sent + 550;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 15) send_noise();
        else run_session({4'd0, ($urandom_range(9) < 8) ? 4'd0 : 4'($urandom_range(1, 2)),
                          4'($urandom_range(5)), 4'($urandom_range(9))}, 100000);
      end
    end
    run_session(16'h9959, 8);
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && pending_readouts.size() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_readouts.size() != 0) report("results missing", 0, pending_readouts.size());
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
